// ===== rtl/core/gfrs_pkg.sv =====
// gfrs_pkg: shared constants, types and helpers of the frame reorder scheduler
// no dependencies; imported by the interfaces and all rtl/core modules but gfrs_ram
package gfrs_pkg;

    localparam int MAX_GOP_LEN_DEF  = 16;
    localparam int HANDLE_WIDTH_DEF = 8;
    localparam int RING_MULT        = 3;

    localparam int GOP_W      = 5;
    localparam int IP_W       = 10;
    localparam int POC_W      = 40;
    localparam int TIME_W     = 64;
    localparam int EXT_HND_W  = 8;
    localparam int CNT_W      = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;
    localparam int DIV_W      = 34;
    localparam int DVS_W      = 11;
    localparam int POS_W      = 7;
    localparam int T_W        = 6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GOP_LENGTH    = 3'd0,
        REG_LOW_DELAY     = 3'd1,
        REG_OPEN_GOP      = 3'd2,
        REG_INTRA_PERIOD  = 3'd3,
        REG_POC_LOW       = 3'd4,
        REG_POC_HIGH      = 3'd5
    } gfrs_reg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_PT_FN_FO,
        OP_PT_FN_REM,
        OP_PT_POS_ZERO,
        OP_PT_POS_REM,
        OP_PT_EMIT,
        OP_SLOT_BM1,
        OP_SLOT_REM,
        OP_FEED_WRITE,
        OP_SD_FEED,
        OP_TMP_LOAD,
        OP_SD_DRAIN,
        OP_ZERO_DTS,
        OP_BASE_REM,
        OP_EXTRA,
        OP_IDX_GS,
        OP_SKIP_STEP,
        OP_IDX_FOUND,
        OP_DTS_ADD,
        OP_DTS_DEC,
        OP_EMIT
    } gfrs_op_t;

    typedef enum logic [3:0] {
        DS_PT_IP,
        DS_PT_G,
        DS_FEED,
        DS_LAST,
        DS_NG,
        DS_NIP,
        DS_NXG,
        DS_NB,
        DS_DIB,
        DS_IDXB
    } gfrs_dsel_t;

    typedef struct packed {
        gfrs_op_t   op;
        logic       take;
        logic       div_start;
        gfrs_dsel_t div_sel;
    } gfrs_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic pt;
        logic action;
        logic g_zero;
        logic ip_zero;
        logic fi_zero;
        logic fi_lt_t;
        logic fi_eq_t;
        logic fo_eq_fi;
        logic fo_zero;
        logic first;
        logic reorder_ip;
        logic closed_hit;
        logic pos_ge_t;
        logic idx_lt;
        logic idx_neg;
        logic fo1_lt_g;
        logic div_done;
        logic slot_valid;
        logic out_free;
    } gfrs_status_t;

    function automatic logic [GOP_W-1:0] poc_entry(input logic [POC_W-1:0] lo,
                                                   input logic [POC_W-1:0] hi,
                                                   input logic [POS_W-1:0] pos);
        logic [GOP_W-1:0] v;
        v = '0;
        if (pos < POS_W'(8))
        begin
            v = lo[5*pos[2:0] +: GOP_W];
        end
        else if (pos < POS_W'(16))
        begin
            v = hi[5*pos[2:0] +: GOP_W];
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/gfrs_item_if.sv =====
// gfrs_item_if: request channel carrying one input item
// depends on gfrs_pkg
interface gfrs_item_if;
    import gfrs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [EXT_HND_W-1:0]     frame_handle;
    logic signed [TIME_W-1:0] pres_time;
    logic                     first_encoded;

    modport source (output valid, action, frame_handle, pres_time, first_encoded, input ready);
    modport sink (input valid, action, frame_handle, pres_time, first_encoded, output ready);
endinterface

// ===== rtl/core/gfrs_result_if.sv =====
// gfrs_result_if: request channel carrying one result item
// depends on gfrs_pkg
interface gfrs_result_if;
    import gfrs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [EXT_HND_W-1:0]     out_handle;
    logic signed [TIME_W-1:0] decode_time;
    logic [GOP_W-1:0]         gop_position;

    modport source (output valid, out_handle, decode_time, gop_position, input ready);
    modport sink (input valid, out_handle, decode_time, gop_position, output ready);
endinterface

// ===== rtl/core/gfrs_cfg_if.sv =====
// gfrs_cfg_if: register write channel
// depends on gfrs_pkg
interface gfrs_cfg_if;
    import gfrs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/gop_frame_reorder_scheduler_top.sv =====
// Frame reorder scheduler: takes fed frames or drain requests, one at a time, and returns the
// next frame to encode with its decode time and GOP position. Frames sit in a ring of
// 3*MAX_GOP_LEN slots held in two RAMs with per-slot valid flip-flops, so no clearing pass is
// needed after reset. All modulo and division work runs on one shared divider that produces one
// quotient bit per cycle; the search for a reordered frame steps over skipped GOP entries one
// at a time. A finished result sits in an output register, so the next item is taken while it
// waits.
module gop_frame_reorder_scheduler_top #(
    parameter int MAX_GOP_LEN  = gfrs_pkg::MAX_GOP_LEN_DEF,
    parameter int HANDLE_WIDTH = gfrs_pkg::HANDLE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gfrs_item_if.sink     item,
    gfrs_result_if.source result,
    gfrs_cfg_if.sink      cfg
);
    import gfrs_pkg::*;

    gfrs_cmd_t    cmd;
    gfrs_status_t st;

    gfrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    gfrs_datapath #(
        .MAX_GOP_LEN  (MAX_GOP_LEN),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .st     (st),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );
endmodule

// ===== rtl/core/gfrs_ram.sv =====
// gfrs_ram: generic single write port ram with registered read
// no dependencies
module gfrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/gfrs_div.sv =====
// gfrs_div: restoring divider, one quotient bit per cycle
// depends on gfrs_pkg
module gfrs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gfrs_pkg::DIV_W-1:0] dividend,
    input  logic [gfrs_pkg::DVS_W-1:0] divisor,
    output logic [gfrs_pkg::DIV_W-1:0] quotient,
    output logic [gfrs_pkg::DVS_W-1:0] remainder,
    output logic                       done
);
    import gfrs_pkg::*;
    localparam int CW = $clog2(DIV_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DIV_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;
endmodule

// ===== rtl/core/gfrs_ctrl.sv =====
// gfrs_ctrl: sequencing state machine of the frame reorder scheduler
// depends on gfrs_pkg; drives the datapath by command and reads its status
module gfrs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gfrs_pkg::gfrs_status_t st,
    output gfrs_pkg::gfrs_cmd_t    cmd
);
    import gfrs_pkg::*;

    typedef enum logic [28:0] {
        S_IDLE     = (29'd1 << 0),
        S_CLASSIFY = (29'd1 << 1),
        S_PT_IPW   = (29'd1 << 2),
        S_PT_GDIV  = (29'd1 << 3),
        S_PT_GW    = (29'd1 << 4),
        S_PT_EMIT  = (29'd1 << 5),
        S_FD_W     = (29'd1 << 6),
        S_FD_WRITE = (29'd1 << 7),
        S_FD_CHK   = (29'd1 << 8),
        S_SD_FEED  = (29'd1 << 9),
        S_DR_W     = (29'd1 << 10),
        S_DR_TMP   = (29'd1 << 11),
        S_DR_SD    = (29'd1 << 12),
        S_OUT_SEL  = (29'd1 << 13),
        S_Z_DTS    = (29'd1 << 14),
        S_NG_W     = (29'd1 << 15),
        S_NIP_W    = (29'd1 << 16),
        S_NXG_DIV  = (29'd1 << 17),
        S_CL_CHK   = (29'd1 << 18),
        S_SRCH     = (29'd1 << 19),
        S_DT_SEL   = (29'd1 << 20),
        S_DTA_W    = (29'd1 << 21),
        S_DTB_W    = (29'd1 << 22),
        S_DTA_SET  = (29'd1 << 23),
        S_DTB_SET  = (29'd1 << 24),
        S_SLOT_SEL = (29'd1 << 25),
        S_SL_W     = (29'd1 << 26),
        S_SL_CHK   = (29'd1 << 27),
        S_SL_EMIT  = (29'd1 << 28)
    } gfrs_state_t;

    gfrs_state_t state_reg;
    gfrs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NOP;
        cmd.take      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DS_FEED;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (st.in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                priority if (st.pt && st.action)
                begin
                    state_next = S_IDLE;
                end
                else if (st.pt && st.g_zero)
                begin
                    cmd.op     = OP_PT_POS_ZERO;
                    state_next = S_PT_EMIT;
                end
                else if (st.pt && !st.ip_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_PT_IP;
                    state_next    = S_PT_IPW;
                end
                else if (st.pt)
                begin
                    cmd.op     = OP_PT_FN_FO;
                    state_next = S_PT_GDIV;
                end
                else if (!st.action && st.fi_zero)
                begin
                    cmd.op     = OP_SLOT_BM1;
                    state_next = S_FD_WRITE;
                end
                else if (!st.action)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_FEED;
                    state_next    = S_FD_W;
                end
                else if (st.fo_eq_fi)
                begin
                    state_next = S_IDLE;
                end
                else if (st.fi_lt_t)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_LAST;
                    state_next    = S_DR_W;
                end
                else
                begin
                    state_next = S_OUT_SEL;
                end
            end
            S_PT_IPW:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_PT_FN_REM;
                    state_next = S_PT_GDIV;
                end
            end
            S_PT_GDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_PT_G;
                state_next    = S_PT_GW;
            end
            S_PT_GW:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_PT_POS_REM;
                    state_next = S_PT_EMIT;
                end
            end
            S_PT_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_PT_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_FD_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_SLOT_REM;
                    state_next = S_FD_WRITE;
                end
            end
            S_FD_WRITE:
            begin
                cmd.op     = OP_FEED_WRITE;
                state_next = S_FD_CHK;
            end
            S_FD_CHK:
            begin
                priority if (st.fi_lt_t)
                begin
                    state_next = S_IDLE;
                end
                else if (st.fi_eq_t)
                begin
                    cmd.op     = OP_SLOT_BM1;
                    state_next = S_SD_FEED;
                end
                else if (st.fo_eq_fi)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OUT_SEL;
                end
            end
            S_SD_FEED:
            begin
                cmd.op     = OP_SD_FEED;
                state_next = st.fo_eq_fi ? S_IDLE : S_OUT_SEL;
            end
            S_DR_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_SLOT_REM;
                    state_next = S_DR_TMP;
                end
            end
            S_DR_TMP:
            begin
                cmd.op     = OP_TMP_LOAD;
                state_next = S_DR_SD;
            end
            S_DR_SD:
            begin
                cmd.op     = OP_SD_DRAIN;
                state_next = S_OUT_SEL;
            end
            S_OUT_SEL:
            begin
                priority if (st.fo_zero)
                begin
                    cmd.op     = OP_SLOT_BM1;
                    state_next = S_Z_DTS;
                end
                else if (!st.first)
                begin
                    state_next = S_IDLE;
                end
                else if (st.reorder_ip)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_NIP;
                    state_next    = S_NIP_W;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_NG;
                    state_next    = S_NG_W;
                end
            end
            S_Z_DTS:
            begin
                cmd.op     = OP_ZERO_DTS;
                state_next = S_SL_CHK;
            end
            S_NIP_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_EXTRA;
                    state_next = S_NXG_DIV;
                end
            end
            S_NXG_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_NXG;
                state_next    = S_NG_W;
            end
            S_NG_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_BASE_REM;
                    state_next = S_CL_CHK;
                end
            end
            S_CL_CHK:
            begin
                if (st.closed_hit)
                begin
                    cmd.op     = OP_IDX_GS;
                    state_next = S_DT_SEL;
                end
                else
                begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                priority if (st.pos_ge_t)
                begin
                    state_next = S_IDLE;
                end
                else if (st.idx_lt)
                begin
                    cmd.op     = OP_IDX_FOUND;
                    state_next = S_DT_SEL;
                end
                else
                begin
                    cmd.op = OP_SKIP_STEP;
                end
            end
            S_DT_SEL:
            begin
                cmd.div_start = 1'b1;
                if (st.fo1_lt_g)
                begin
                    cmd.div_sel = DS_NB;
                    state_next  = S_DTA_W;
                end
                else
                begin
                    cmd.div_sel = DS_DIB;
                    state_next  = S_DTB_W;
                end
            end
            S_DTA_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_SLOT_REM;
                    state_next = S_DTA_SET;
                end
            end
            S_DTB_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_SLOT_REM;
                    state_next = S_DTB_SET;
                end
            end
            S_DTA_SET:
            begin
                cmd.op     = OP_DTS_ADD;
                state_next = S_SLOT_SEL;
            end
            S_DTB_SET:
            begin
                cmd.op     = OP_DTS_DEC;
                state_next = S_SLOT_SEL;
            end
            S_SLOT_SEL:
            begin
                if (st.idx_neg)
                begin
                    cmd.op     = OP_SLOT_BM1;
                    state_next = S_SL_CHK;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_IDXB;
                    state_next    = S_SL_W;
                end
            end
            S_SL_W:
            begin
                if (st.div_done)
                begin
                    cmd.op     = OP_SLOT_REM;
                    state_next = S_SL_CHK;
                end
            end
            S_SL_CHK:
            begin
                state_next = st.slot_valid ? S_SL_EMIT : S_IDLE;
            end
            S_SL_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/gfrs_datapath.sv =====
// gfrs_datapath: registers, frame ring, shared divider and channel ports
// depends on gfrs_pkg, gfrs_ram, gfrs_div and the channel interfaces
module gfrs_datapath #(
    parameter int MAX_GOP_LEN  = gfrs_pkg::MAX_GOP_LEN_DEF,
    parameter int HANDLE_WIDTH = gfrs_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gfrs_pkg::gfrs_cmd_t    cmd,
    output gfrs_pkg::gfrs_status_t st,
    gfrs_item_if.sink              item,
    gfrs_result_if.source          result,
    gfrs_cfg_if.sink               cfg
);
    import gfrs_pkg::*;

    localparam int RING_DEPTH = RING_MULT * MAX_GOP_LEN;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int BW         = $clog2(RING_DEPTH + 1);

    logic [GOP_W-1:0]  gop_len_reg;
    logic              low_delay_reg;
    logic              open_gop_reg;
    logic [IP_W-1:0]   intra_reg;
    logic [POC_W-1:0]  poc_lo_reg;
    logic [POC_W-1:0]  poc_hi_reg;

    logic              act_reg;
    logic [HANDLE_WIDTH-1:0] hnd_reg;
    logic [TIME_W-1:0] pts_reg;
    logic              first_reg;

    logic [CNT_W-1:0]  fi_reg;
    logic [CNT_W-1:0]  fo_reg;
    logic [TIME_W-1:0] sd_reg;
    logic [GOP_W-1:0]  skip_reg;
    logic [GOP_W-1:0]  skw_reg;
    logic [CNT_W-1:0]  fn_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  extra_reg;
    logic [IP_W-1:0]   remip_reg;
    logic [DIV_W-1:0]  gs_reg;
    logic [DIV_W-1:0]  idx_reg;
    logic [TIME_W-1:0] tmp_reg;
    logic [TIME_W-1:0] dts_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [RING_DEPTH-1:0] valid_reg;
    logic [RING_DEPTH-1:0] tw_reg;
    logic              tw_q_reg;

    logic              out_valid_reg;
    logic [EXT_HND_W-1:0] out_hnd_reg;
    logic [TIME_W-1:0] out_dts_reg;
    logic [GOP_W-1:0]  out_pos_reg;

    logic [GOP_W-1:0]  g;
    logic [BW-1:0]     b;
    logic [SLOT_W-1:0] b_m1;
    logic              closed;
    logic [T_W-1:0]    t;
    logic [CNT_W-1:0]  n;
    logic [DIV_W-1:0]  idx_c;
    logic [TIME_W-1:0] tv;
    logic [TIME_W-1:0] t_rdata;
    logic [HANDLE_WIDTH-1:0] h_rdata;
    logic              out_free;

    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_q;
    logic [DVS_W-1:0]  div_r;
    logic              div_done;

    assign g      = (32'(gop_len_reg) > MAX_GOP_LEN) ? GOP_W'(MAX_GOP_LEN) : gop_len_reg;
    assign b      = BW'(g) + BW'({g, 1'b0});
    assign b_m1   = SLOT_W'(b - BW'(1));
    assign closed = !open_gop_reg && (intra_reg != '0) && (g != '0);
    assign t      = T_W'(g) + T_W'(closed);
    assign n      = fo_reg - CNT_W'(1);
    assign idx_c  = gs_reg + DIV_W'(poc_entry(poc_lo_reg, poc_hi_reg, pos_reg)) - DIV_W'(1);
    assign tv     = tw_q_reg ? t_rdata : '0;
    assign out_free = !out_valid_reg || result.ready;

    // divider operand selection
    always_comb
    begin
        div_dividend = DIV_W'(fi_reg) - DIV_W'(1);
        div_divisor  = DVS_W'(b);
        unique case (cmd.div_sel)
            DS_PT_IP:
            begin
                div_dividend = DIV_W'(fo_reg);
                div_divisor  = DVS_W'(intra_reg);
            end
            DS_PT_G:
            begin
                div_dividend = DIV_W'(fn_reg) + DIV_W'(g) - DIV_W'(1);
                div_divisor  = DVS_W'(g);
            end
            DS_FEED:
            begin
                div_dividend = DIV_W'(fi_reg) - DIV_W'(1);
            end
            DS_LAST:
            begin
                div_dividend = DIV_W'(fi_reg) + DIV_W'(b) - DIV_W'(2);
            end
            DS_NG:
            begin
                div_dividend = DIV_W'(n);
                div_divisor  = DVS_W'(g);
            end
            DS_NIP:
            begin
                div_dividend = DIV_W'(n);
                div_divisor  = DVS_W'(intra_reg) + DVS_W'(1);
            end
            DS_NXG:
            begin
                div_dividend = DIV_W'(n) - DIV_W'(extra_reg);
                div_divisor  = DVS_W'(g);
            end
            DS_NB:
            begin
                div_dividend = DIV_W'(n);
            end
            DS_DIB:
            begin
                div_dividend = DIV_W'(fo_reg - CNT_W'(g) + CNT_W'(1));
            end
            DS_IDXB:
            begin
                div_dividend = idx_reg;
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    gfrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    always_comb
    begin
        slot_next = slot_reg;
        priority case (cmd.op)
            OP_SLOT_BM1, OP_TMP_LOAD: slot_next = b_m1;
            OP_SLOT_REM:              slot_next = SLOT_W'(div_r);
            default:                  slot_next = slot_reg;
        endcase
    end

    gfrs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RING_DEPTH)
    ) u_time_ram (
        .clk   (clk),
        .we    (cmd.op == OP_FEED_WRITE),
        .waddr (slot_reg),
        .wdata (pts_reg),
        .raddr (slot_next),
        .rdata (t_rdata)
    );

    gfrs_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (RING_DEPTH)
    ) u_handle_ram (
        .clk   (clk),
        .we    (cmd.op == OP_FEED_WRITE),
        .waddr (slot_reg),
        .wdata (hnd_reg),
        .raddr (slot_next),
        .rdata (h_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gop_len_reg   <= '0;
            low_delay_reg <= 1'b0;
            open_gop_reg  <= 1'b0;
            intra_reg     <= '0;
            poc_lo_reg    <= '0;
            poc_hi_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                REG_GOP_LENGTH:   gop_len_reg   <= cfg.data[GOP_W-1:0];
                REG_LOW_DELAY:    low_delay_reg <= cfg.data[0];
                REG_OPEN_GOP:     open_gop_reg  <= cfg.data[0];
                REG_INTRA_PERIOD: intra_reg     <= cfg.data[IP_W-1:0];
                REG_POC_LOW:      poc_lo_reg    <= cfg.data[POC_W-1:0];
                REG_POC_HIGH:     poc_hi_reg    <= cfg.data[POC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg        <= '0;
            fo_reg        <= '0;
            sd_reg        <= '0;
            skip_reg      <= '0;
            valid_reg     <= '0;
            tw_reg        <= '0;
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
            tw_q_reg      <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            tw_q_reg <= tw_reg[slot_next];
            if (cmd.op == OP_PT_EMIT || cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_PT_EMIT:
                begin
                    fi_reg <= fi_reg + CNT_W'(1);
                    fo_reg <= fo_reg + CNT_W'(1);
                end
                OP_FEED_WRITE:
                begin
                    fi_reg             <= fi_reg + CNT_W'(1);
                    valid_reg[slot_reg] <= 1'b1;
                    tw_reg[slot_reg]    <= 1'b1;
                end
                OP_SD_FEED:  sd_reg <= tv - pts_reg;
                OP_SD_DRAIN: sd_reg <= tv - tmp_reg;
                OP_EMIT:
                begin
                    valid_reg[slot_reg] <= 1'b0;
                    skip_reg            <= skw_reg;
                    fo_reg              <= fo_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                act_reg   <= item.action;
                hnd_reg   <= HANDLE_WIDTH'(item.frame_handle);
                pts_reg   <= item.pres_time;
                first_reg <= item.first_encoded;
            end
            OP_PT_FN_FO:    fn_reg  <= fo_reg;
            OP_PT_FN_REM:   fn_reg  <= CNT_W'(div_r);
            OP_PT_POS_ZERO: pos_reg <= '0;
            OP_PT_POS_REM:  pos_reg <= POS_W'(div_r);
            OP_PT_EMIT:
            begin
                out_hnd_reg <= EXT_HND_W'(hnd_reg);
                out_dts_reg <= pts_reg;
                out_pos_reg <= pos_reg[GOP_W-1:0];
            end
            OP_TMP_LOAD: tmp_reg <= tv;
            OP_ZERO_DTS:
            begin
                dts_reg <= tv + sd_reg;
                pos_reg <= '0;
                skw_reg <= skip_reg;
            end
            OP_EXTRA:
            begin
                extra_reg <= CNT_W'(div_q);
                remip_reg <= IP_W'(div_r);
            end
            OP_BASE_REM:
            begin
                gs_reg  <= DIV_W'(n) - DIV_W'(div_r);
                pos_reg <= POS_W'(div_r) + POS_W'(skip_reg);
                skw_reg <= skip_reg;
            end
            OP_IDX_GS:    idx_reg <= gs_reg;
            OP_IDX_FOUND: idx_reg <= idx_c;
            OP_SKIP_STEP:
            begin
                skw_reg <= skw_reg + GOP_W'(1);
                pos_reg <= pos_reg + POS_W'(1);
            end
            OP_DTS_ADD: dts_reg <= tv + sd_reg;
            OP_DTS_DEC: dts_reg <= tv - TIME_W'(1);
            OP_EMIT:
            begin
                out_hnd_reg <= EXT_HND_W'(h_rdata);
                out_dts_reg <= dts_reg;
                out_pos_reg <= pos_reg[GOP_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign item.ready          = cmd.take;
    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.out_handle   = out_hnd_reg;
    assign result.decode_time  = out_dts_reg;
    assign result.gop_position = out_pos_reg;

    assign st.in_valid   = item.valid;
    assign st.pt         = (g == '0) || low_delay_reg;
    assign st.action     = act_reg;
    assign st.g_zero     = (g == '0);
    assign st.ip_zero    = (intra_reg == '0);
    assign st.fi_zero    = (fi_reg == '0);
    assign st.fi_lt_t    = fi_reg < CNT_W'(t);
    assign st.fi_eq_t    = fi_reg == CNT_W'(t);
    assign st.fo_eq_fi   = fo_reg == fi_reg;
    assign st.fo_zero    = (fo_reg == '0);
    assign st.first      = first_reg;
    assign st.reorder_ip = !open_gop_reg && (intra_reg != '0);
    assign st.closed_hit = closed && (remip_reg == intra_reg);
    assign st.pos_ge_t   = pos_reg >= POS_W'(t);
    assign st.idx_lt     = $signed(idx_c) < $signed(DIV_W'(fi_reg) - DIV_W'(1));
    assign st.idx_neg    = idx_reg[DIV_W-1];
    assign st.fo1_lt_g   = (33'(fo_reg) + 33'd1) < 33'(g);
    assign st.div_done   = div_done;
    assign st.slot_valid = valid_reg[slot_reg];
    assign st.out_free   = out_free;
endmodule

// ===== tb/sv/gop_frame_reorder_scheduler_top_tb.sv =====
// gop_frame_reorder_scheduler_top_tb: self-checking testbench of the frame reorder scheduler
// predicts every result from its own copy of ring, counters and registers; checks in order
// depends on gfrs_pkg, the gfrs_*_if interfaces and gop_frame_reorder_scheduler_top
`timescale 1ns / 100ps

module gop_frame_reorder_scheduler_top_tb;
    import gfrs_pkg::*;

    typedef struct packed {
        logic [7:0]  handle;
        logic [63:0] dts;
        logic [4:0]  pos;
    } frame_out_t;

    localparam int DEPTH = RING_MULT * MAX_GOP_LEN_DEF;
    localparam int DOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    gfrs_item_if   item_ch ();
    gfrs_result_if res_ch ();
    gfrs_cfg_if    cfg_ch ();

    gop_frame_reorder_scheduler_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // scheduler copy
    bit [4:0]  m_gop;
    bit        m_low_delay;
    bit        m_open;
    bit [9:0]  m_intra;
    bit [39:0] m_poc_lo;
    bit [39:0] m_poc_hi;
    bit        m_slot_full [DEPTH];
    bit [7:0]  m_handle [DEPTH];
    bit [63:0] m_time [DEPTH];
    bit [31:0] m_fin;
    bit [31:0] m_fout;
    bit [63:0] m_delay;
    bit [4:0]  m_skip;

    frame_out_t pending_frames[$];
    int  fails;
    int  mismatches;
    int  src_idle_pct;
    int  snk_idle_pct;
    int  hold_cycles;
    int  quiet_cycles;
    bit [63:0] pts_run;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned poc_at(longint unsigned i);
        if (i < 8)
        begin
            return (m_poc_lo >> (5 * i)) & 31;
        end
        if (i < 16)
        begin
            return (m_poc_hi >> (5 * (i - 8))) & 31;
        end
        return 0;
    endfunction

    function automatic bit schedule(input bit act, input bit [7:0] h, input bit [63:0] pts,
                                    input bit fd, output frame_out_t r);
        longint unsigned g, b, t, slot, n, gs, pos, fn, extra, last;
        longint idx;
        bit [63:0] dts;
        bit [31:0] di;
        bit [4:0] skip;
        bit closed;
        g = (m_gop > 16) ? 16 : m_gop;
        closed = (m_open == 0) && (m_intra > 0) && (g > 0);
        r = '0;
        if (g == 0 || m_low_delay)
        begin
            if (act)
            begin
                return 0;
            end
            pos = 0;
            if (g > 0)
            begin
                fn = m_fout;
                if (m_intra != 0)
                begin
                    fn = fn % m_intra;
                end
                pos = (fn + g - 1) % g;
            end
            m_fin++;
            m_fout++;
            r = '{h, pts, pos[4:0]};
            return 1;
        end
        b = RING_MULT * g;
        t = g + (closed ? 1 : 0);
        if (!act)
        begin
            slot = (m_fin == 0) ? b - 1 : (longint'(m_fin) - 1) % b;
            m_slot_full[slot] = 1;
            m_handle[slot] = h;
            m_time[slot] = pts;
            m_fin++;
            if (m_fin < t)
            begin
                return 0;
            end
            if (m_fin == t)
            begin
                m_delay = m_time[b-1] - pts;
            end
        end
        if (m_fout == m_fin)
        begin
            return 0;
        end
        if (act && m_fin < t)
        begin
            last = (longint'(m_fin) + b - 2) % b;
            m_delay = m_time[b-1] - m_time[last];
        end
        skip = m_skip;
        if (m_fout == 0)
        begin
            idx = -1;
            dts = m_time[b-1] + m_delay;
            pos = 0;
        end
        else if (fd)
        begin
            n = longint'(m_fout) - 1;
            pos = n % g;
            if (m_open == 0 && m_intra > 0)
            begin
                extra = n / (m_intra + 1);
                pos = (n - extra) % g;
            end
            gs = n - pos;
            pos += skip;
            if (closed && (n % (m_intra + 1)) == m_intra)
            begin
                idx = gs;
            end
            else
            begin
                forever
                begin
                    if (pos >= t)
                    begin
                        return 0;
                    end
                    idx = longint'(gs) + longint'(poc_at(pos)) - 1;
                    if (idx < longint'(m_fin) - 1)
                    begin
                        break;
                    end
                    skip = skip + 1;
                    pos++;
                end
            end
            if (longint'(m_fout) + 1 < g)
            begin
                dts = m_time[n % b] + m_delay;
            end
            else
            begin
                di = m_fout - 32'(g - 1);
                dts = m_time[longint'(di) % b] - 1;
            end
        end
        else
        begin
            return 0;
        end
        slot = (idx < 0) ? b - 1 : longint'(idx) % b;
        if (!m_slot_full[slot])
        begin
            return 0;
        end
        m_slot_full[slot] = 0;
        r = '{m_handle[slot], dts, pos[4:0]};
        m_skip = skip;
        m_fout++;
        return 1;
    endfunction

    task automatic send_frame(input bit act, input bit [7:0] h, input bit [63:0] pts,
                              input bit fd);
        frame_out_t r;
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.action        <= act;
        item_ch.frame_handle  <= h;
        item_ch.pres_time     <= pts;
        item_ch.first_encoded <= fd;
        do @(posedge clk); while (!item_ch.ready);
        if (schedule(act, h, pts, fd, r))
        begin
            pending_frames.push_back(r);
        end
    endtask

    task automatic send_random;
        bit act;
        bit [63:0] pts;
        act = ($urandom_range(9) == 0);
        if ($urandom_range(19) == 0)
        begin
            pts = {$urandom, $urandom};
        end
        else
        begin
            pts_run += $urandom_range(1, 4);
            pts = pts_run;
        end
        send_frame(act, 8'($urandom), pts, $urandom_range(15) != 0);
    endtask

    task automatic settle;
        item_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    task automatic write_regs(input bit [4:0] gop, input bit ld, input bit og,
                              input bit [9:0] ip, input bit [39:0] lo, input bit [39:0] hi);
        gfrs_reg_t idx [6];
        bit [39:0] val [6];
        idx = '{REG_GOP_LENGTH, REG_LOW_DELAY, REG_OPEN_GOP, REG_INTRA_PERIOD,
                REG_POC_LOW, REG_POC_HIGH};
        val = '{40'(gop), 40'(ld), 40'(og), 40'(ip), lo, hi};
        for (int i = 0; i < 6; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.addr  <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        m_gop = gop;
        m_low_delay = ld;
        m_open = og;
        m_intra = ip;
        m_poc_lo = lo;
        m_poc_hi = hi;
    endtask

    // poc table: shuffled 1..g, with an occasional random entry
    function automatic bit [79:0] make_table(int g);
        bit [79:0] tbl;
        int order [16];
        int j, tmp;
        for (int i = 0; i < 16; i++)
        begin
            order[i] = i + 1;
        end
        for (int i = g - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        tbl = '0;
        for (int i = 0; i < 16; i++)
        begin
            tbl[5*i +: 5] = ($urandom_range(15) == 0) ? 5'($urandom) : 5'(order[i]);
        end
        return tbl;
    endfunction

    task automatic run_phase(input int items);
        bit [79:0] tbl;
        int g;
        g = $urandom_range(1, 16);
        if ($urandom_range(5) == 0)
        begin
            g = $urandom_range(0, 31);
        end
        tbl = make_table((g > 16) ? 16 : ((g == 0) ? 1 : g));
        write_regs(5'(g), $urandom_range(7) == 0, $urandom_range(1),
                   ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40)),
                   tbl[39:0], tbl[79:40]);
        repeat (items) send_random();
        repeat (3 * 16 + 2) send_frame(1'b1, 8'($urandom), 64'($urandom), 1'b1);
        settle();
    endtask

    task automatic test_directed;
        write_regs(5'd0, 1'b0, 1'b0, 10'd0, 40'd0, 40'd0);
        send_frame(1'b0, 8'h00, 64'h8000_0000_0000_0000, 1'b0);
        send_frame(1'b0, 8'hff, 64'h7fff_ffff_ffff_ffff, 1'b1);
        send_frame(1'b1, 8'h5a, 64'hffff_ffff_ffff_ffff, 1'b1);
        settle();
        write_regs(5'd16, 1'b1, 1'b1, 10'd1023, 40'hff_ffff_ffff, 40'hff_ffff_ffff);
        repeat (4) send_frame(1'b0, 8'($urandom), {$urandom, $urandom}, 1'b1);
        settle();
        // closed gop of eight with a short intra period
        write_regs(5'd8, 1'b0, 1'b0, 10'd3,
                   {5'd7, 5'd5, 5'd6, 5'd3, 5'd1, 5'd2, 5'd4, 5'd8}, 40'd0);
        for (int i = 0; i < 10; i++)
        begin
            send_frame(1'b0, 8'(i), 64'(i * 2), i > 3);
        end
        send_frame(1'b1, 8'h00, 64'd0, 1'b0);
        repeat (4) send_frame(1'b1, 8'h00, 64'd0, 1'b1);
        settle();
        // open gop of one, drain before the start
        write_regs(5'd1, 1'b0, 1'b1, 10'd0, 40'd0, 40'd0);
        send_frame(1'b1, 8'h11, 64'd5, 1'b1);
        send_frame(1'b0, 8'h22, 64'hffff_ffff_ffff_fffe, 1'b1);
        send_frame(1'b0, 8'h33, 64'd1, 1'b1);
        send_frame(1'b1, 8'h44, 64'd0, 1'b1);
        settle();
    endtask

    task automatic test_random_phases(input int phases);
        for (int p = 0; p < phases; p++)
        begin
            run_phase($urandom_range(30, 70));
        end
    endtask

    task automatic test_backpressure;
        bit [79:0] tbl;
        tbl = make_table(16);
        write_regs(5'd16, 1'b0, 1'b0, 10'd5, tbl[39:0], tbl[79:40]);
        hold_cycles = 1500;
        repeat (60) send_random();
        settle();
        repeat (30) send_random();
        settle();
        repeat (40) send_random();
        repeat (50) send_frame(1'b1, 8'h00, 64'd0, 1'b1);
        settle();
    endtask

    // result side: random stalls, long hold-off, in-order check
    always @(posedge clk)
    begin
        frame_out_t e;
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                fails++;
                $display("unexpected result handle %0h", res_ch.out_handle);
            end
            else
            begin
                e = pending_frames.pop_front();
                if (res_ch.out_handle !== e.handle || res_ch.decode_time !== e.dts ||
                    res_ch.gop_position !== e.pos)
                begin
                    fails++;
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp h=%0h dts=%0h pos=%0d got h=%0h dts=%0h pos=%0d",
                                 e.handle, e.dts, e.pos, res_ch.out_handle,
                                 res_ch.decode_time, res_ch.gop_position);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= DOG_LIMIT)
        begin
            $display("FAIL gop_frame_reorder_scheduler_top");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        fails = 0;
        mismatches = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        pts_run = 64'hffff_ffff_ffff_ff00;
        src_idle_pct = 18;
        snk_idle_pct = 64;
        m_gop = 0;
        m_low_delay = 0;
        m_open = 0;
        m_intra = 0;
        m_poc_lo = 0;
        m_poc_hi = 0;
        m_fin = 0;
        m_fout = 0;
        m_delay = 0;
        m_skip = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            m_slot_full[i] = 0;
            m_handle[i] = 0;
            m_time[i] = 0;
        end
        item_ch.valid = 1'b0;
        item_ch.action = 1'b0;
        item_ch.frame_handle = '0;
        item_ch.pres_time = '0;
        item_ch.first_encoded = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phases(5);
        src_idle_pct = 64;
        snk_idle_pct = 18;
        test_random_phases(5);
        test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_phases(4);

        settle();
        if (fails == 0)
        begin
            $display("PASS gop_frame_reorder_scheduler_top");
        end
        else
        begin
            $display("FAIL gop_frame_reorder_scheduler_top");
        end
        $finish;
    end
endmodule
